/* hdl/fcpr_pkg.sv */
// shared types, constants and codes for the filled circle page rasteriser
package fcpr_pkg;

    // display geometry
    localparam int DISP_W = 128;
    localparam int DISP_H = 64;

    // field widths
    localparam int CMD_W   = 2;
    localparam int CX_W    = 7;
    localparam int CY_W    = 6;
    localparam int DIR_W   = 2;
    localparam int OFS_W   = 6;
    localparam int RAD_W   = 5;
    localparam int SPD_W   = 3;
    localparam int PAGE_W  = 3;
    localparam int PIX_W   = 8;
    localparam int STAT_W  = 2;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int BIT_W   = $clog2(RAD_W);
    localparam int STEP_W  = PAGE_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RAD_W;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VSPEED = 1'b1;

    // reset values of the registers
    localparam logic [RAD_W-1:0] RADIUS_RST = 5'd8;
    localparam logic [SPD_W-1:0] VSPEED_RST = 3'd1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

    // direction patterns, any other pattern stands still
    localparam logic [DIR_W-1:0] DIR_NEG = 2'b11;
    localparam logic [DIR_W-1:0] DIR_POS = 2'b01;

    // page masks
    localparam logic [PIX_W-1:0] MASK_FULL = 8'hff;

    // job queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one job for the write sequencer
    typedef struct packed {
        logic              wr;
        logic [STAT_W-1:0] status;
        logic [CX_W-1:0]   col;
        logic [PAGE_W-1:0] p_bot;
        logic [PAGE_W-1:0] p_top;
        logic [PIX_W-1:0]  m_bot;
        logic [PIX_W-1:0]  m_top;
        logic [CX_W-1:0]   cx;
        logic [CY_W-1:0]   cy;
    } t_job;

    // queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* hdl/fcpr_queue.sv */
// short job queue between the command front end and the write sequencer
module fcpr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fcpr_pkg::t_job  i_job,
    input  logic            i_pop,
    output fcpr_pkg::t_job  o_job,
    output fcpr_pkg::t_q_stat o_stat
);
    import fcpr_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* hdl/fcpr_front.sv */
// command front end: registers, motion state, half-height square root, job build
module fcpr_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [fcpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fcpr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [fcpr_pkg::CMD_W-1:0]         i_cmd,
    input  logic [fcpr_pkg::CX_W-1:0]          i_center_x_in,
    input  logic [fcpr_pkg::CY_W-1:0]          i_center_y_in,
    input  logic signed [fcpr_pkg::DIR_W-1:0]  i_dir_x_in,
    input  logic signed [fcpr_pkg::DIR_W-1:0]  i_dir_y_in,
    input  logic [fcpr_pkg::OFS_W-1:0]         i_column_offset,
    input  fcpr_pkg::t_q_stat                  i_q_stat,
    output logic                               o_push,
    output fcpr_pkg::t_job                     o_job
);
    import fcpr_pkg::*;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_SQRT = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [RAD_W-1:0] r_radius, n_radius;
    logic [SPD_W-1:0] r_vspeed, n_vspeed;
    logic [CX_W-1:0]  r_cx, n_cx;
    logic [CY_W-1:0]  r_cy, n_cy;
    logic [DIR_W-1:0] r_hdir, n_hdir;
    logic [DIR_W-1:0] r_vdir, n_vdir;
    logic [SQ_W-1:0]  r_v, n_v;
    logic [OFS_W-1:0] r_d, n_d;
    logic [RAD_W-1:0] r_h, n_h;
    logic [BIT_W-1:0] r_bit, n_bit;

    logic accept;

    // motion tick
    logic signed [8:0] tk_xs, tk_ys, tk_rs, tk_xlim, tk_ylim, tk_spd;
    logic signed [8:0] tk_x, tk_y, tk_ymv;
    logic [DIR_W-1:0]  tk_hd, tk_vd;

    // render set-up
    logic              place_ok;
    logic              ofs_range;
    logic signed [6:0] dx_s;
    logic signed [6:0] dx_abs;
    logic [SQ_W-1:0]   rr, dd, v_in;

    // square root step
    logic [RAD_W-1:0]  trial;
    logic [SQ_W-1:0]   trial_sq;

    // column geometry
    logic [CY_W:0]       y_bot_w;
    logic signed [CY_W:0] y_top_w;
    logic [CY_W-1:0]     y_bot, y_top;
    logic signed [9:0]   col_s;
    logic                col_off;
    t_job                rj;

    assign o_in_ready = (r_state == FS_IDLE) && !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    // tick: one column sideways, vert_speed rows up or down, reverse at walls
    always_comb begin
        tk_xs   = $signed({2'b00, r_cx});
        tk_ys   = $signed({3'b000, r_cy});
        tk_rs   = $signed({4'b0000, r_radius});
        tk_spd  = $signed({6'b000000, r_vspeed});
        tk_xlim = $signed(9'(DISP_W - 1)) - tk_rs;
        tk_ylim = $signed(9'(DISP_H - 1)) - tk_rs;
        tk_x    = tk_xs;
        tk_y    = tk_ys;
        tk_ymv  = tk_ys;
        tk_hd   = r_hdir;
        tk_vd   = r_vdir;
        if (r_hdir == DIR_NEG) begin
            if (tk_xs <= tk_rs) tk_hd = DIR_POS;
            else tk_x = tk_xs - 9'sd1;
        end else if (r_hdir == DIR_POS) begin
            if (tk_xs >= tk_xlim) tk_hd = DIR_NEG;
            else tk_x = tk_xs + 9'sd1;
        end
        if (r_vdir == DIR_NEG) begin
            if (tk_ys <= tk_rs) begin
                tk_vd = DIR_POS;
            end else begin
                tk_ymv = tk_ys - tk_spd;
                tk_y   = (tk_ymv < tk_rs) ? tk_rs : tk_ymv;
            end
        end else if (r_vdir == DIR_POS) begin
            if (tk_ys >= tk_ylim) begin
                tk_vd = DIR_NEG;
            end else begin
                tk_ymv = tk_ys + tk_spd;
                tk_y   = (tk_ymv > tk_ylim) ? tk_ylim : tk_ymv;
            end
        end
    end

    // radicand r^2 - dx^2 for a render word
    always_comb begin
        place_ok  = (i_center_x_in >= CX_W'(r_radius)) && (i_center_y_in >= CY_W'(r_radius));
        ofs_range = i_column_offset > {r_radius, 1'b0};
        dx_s      = $signed({1'b0, i_column_offset}) - $signed({2'b00, r_radius});
        dx_abs    = dx_s[6] ? -dx_s : dx_s;
        rr        = SQ_W'(r_radius) * SQ_W'(r_radius);
        dd        = SQ_W'(dx_abs[RAD_W-1:0]) * SQ_W'(dx_abs[RAD_W-1:0]);
        v_in      = rr - dd;
    end

    // one result bit of the square root per cycle
    always_comb begin
        trial    = r_h | (RAD_W'(1) << r_bit);
        trial_sq = SQ_W'(trial) * SQ_W'(trial);
    end

    // column span, clamped rows, edge pages and masks
    always_comb begin
        y_bot_w = {1'b0, r_cy} + {2'b00, r_h};
        y_top_w = $signed({1'b0, r_cy}) - $signed({2'b00, r_h});
        y_bot   = (y_bot_w > (CY_W + 1)'(DISP_H - 1)) ? CY_W'(DISP_H - 1) : y_bot_w[CY_W-1:0];
        y_top   = y_top_w[CY_W] ? '0 : y_top_w[CY_W-1:0];
        col_s   = $signed({3'b000, r_cx}) - $signed({5'b00000, r_radius})
                + $signed({4'b0000, r_d});
        col_off = col_s[9] || (col_s >= $signed(10'(DISP_W)));
        rj        = '0;
        rj.cx     = r_cx;
        rj.cy     = r_cy;
        rj.status = STAT_OK;
        if (!col_off) begin
            rj.wr    = 1'b1;
            rj.col   = col_s[CX_W-1:0];
            rj.p_bot = y_bot[CY_W-1:3];
            rj.p_top = y_top[CY_W-1:3];
            rj.m_bot = PIX_W'((9'd2 << y_bot[2:0]) - 9'd1);
            rj.m_top = MASK_FULL << y_top[2:0];
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_radius = r_radius;
        n_vspeed = r_vspeed;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_hdir   = r_hdir;
        n_vdir   = r_vdir;
        n_v      = r_v;
        n_d      = r_d;
        n_h      = r_h;
        n_bit    = r_bit;
        o_push   = 1'b0;
        o_job    = '0;
        o_job.cx = r_cx;
        o_job.cy = r_cy;

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RADIUS: n_radius = i_cfg_data[RAD_W-1:0];
                CFG_VSPEED: n_vspeed = i_cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_PLACE: begin
                            o_push = 1'b1;
                            if (place_ok) begin
                                n_cx     = i_center_x_in;
                                n_cy     = i_center_y_in;
                                n_hdir   = i_dir_x_in;
                                n_vdir   = i_dir_y_in;
                                o_job.cx = i_center_x_in;
                                o_job.cy = i_center_y_in;
                            end else begin
                                o_job.status = STAT_REJECT;
                            end
                        end
                        CMD_TICK: begin
                            o_push   = 1'b1;
                            n_cx     = tk_x[CX_W-1:0];
                            n_cy     = tk_y[CY_W-1:0];
                            n_hdir   = tk_hd;
                            n_vdir   = tk_vd;
                            o_job.cx = tk_x[CX_W-1:0];
                            o_job.cy = tk_y[CY_W-1:0];
                        end
                        CMD_RENDER: begin
                            if (ofs_range) begin
                                o_push       = 1'b1;
                                o_job.status = STAT_RANGE;
                            end else begin
                                n_v     = v_in;
                                n_d     = i_column_offset;
                                n_h     = '0;
                                n_bit   = BIT_W'(RAD_W - 1);
                                n_state = FS_SQRT;
                            end
                        end
                        default: o_push = 1'b1;
                    endcase
                end
            end
            FS_SQRT: begin
                if (trial_sq <= r_v) n_h = trial;
                if (r_bit == '0) n_state = FS_PUSH;
                else n_bit = r_bit - 1'b1;
            end
            FS_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push  = 1'b1;
                    o_job   = rj;
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // control and motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_radius <= RADIUS_RST;
            r_vspeed <= VSPEED_RST;
            r_cx     <= '0;
            r_cy     <= '0;
            r_hdir   <= '0;
            r_vdir   <= '0;
        end else begin
            r_state  <= n_state;
            r_radius <= n_radius;
            r_vspeed <= n_vspeed;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_hdir   <= n_hdir;
            r_vdir   <= n_vdir;
        end
    end

    // square root working registers
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_d   <= n_d;
        r_h   <= n_h;
        r_bit <= n_bit;
    end

endmodule

/* hdl/fcpr_back.sv */
// write sequencer: expands a queued job into page writes behind an output register
module fcpr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fcpr_pkg::t_job                  i_job,
    input  fcpr_pkg::t_q_stat               i_q_stat,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fcpr_pkg::PAGE_W-1:0]     o_page,
    output logic [fcpr_pkg::CX_W-1:0]       o_column,
    output logic [fcpr_pkg::PIX_W-1:0]      o_pixels,
    output logic                            o_write_valid,
    output logic                            o_last,
    output logic [fcpr_pkg::STAT_W-1:0]     o_status,
    output logic [fcpr_pkg::CX_W-1:0]       o_center_x_out,
    output logic [fcpr_pkg::CY_W-1:0]       o_center_y_out
);
    import fcpr_pkg::*;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_valid, n_valid;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [CX_W-1:0]   r_col, n_col;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic              r_wv, n_wv;
    logic              r_last, n_last;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic [CX_W-1:0]   r_cx, n_cx;
    logic [CY_W-1:0]   r_cy, n_cy;

    logic              emit;
    logic [PAGE_W-1:0] span;

    assign emit = !i_q_stat.empty && (!r_valid || i_out_ready);
    assign span = i_job.p_bot - i_job.p_top;

    // bottom edge page, then top edge page, then full pages top to bottom
    always_comb begin
        n_step  = r_step;
        n_valid = r_valid && !i_out_ready;
        n_page  = r_page;
        n_col   = r_col;
        n_pix   = r_pix;
        n_wv    = r_wv;
        n_last  = r_last;
        n_stat  = r_stat;
        n_cx    = r_cx;
        n_cy    = r_cy;
        o_pop   = 1'b0;
        if (emit) begin
            n_valid = 1'b1;
            n_stat  = i_job.status;
            n_cx    = i_job.cx;
            n_cy    = i_job.cy;
            n_wv    = i_job.wr;
            n_col   = i_job.col;
            if (!i_job.wr) begin
                n_page = '0;
                n_pix  = '0;
                n_last = 1'b1;
            end else begin
                n_last = (r_step == span);
                case (r_step)
                    STEP_W'(0): begin
                        n_page = i_job.p_bot;
                        n_pix  = (span == '0) ? (i_job.m_bot & i_job.m_top) : i_job.m_bot;
                    end
                    STEP_W'(1): begin
                        n_page = i_job.p_top;
                        n_pix  = i_job.m_top;
                    end
                    default: begin
                        n_page = i_job.p_top + r_step - 1'b1;
                        n_pix  = MASK_FULL;
                    end
                endcase
            end
            if (n_last) begin
                o_pop  = 1'b1;
                n_step = '0;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_col  <= n_col;
        r_pix  <= n_pix;
        r_wv   <= n_wv;
        r_last <= n_last;
        r_stat <= n_stat;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
    end

    assign o_out_valid    = r_valid;
    assign o_page         = r_page;
    assign o_column       = r_col;
    assign o_pixels       = r_pix;
    assign o_write_valid  = r_wv;
    assign o_last         = r_last;
    assign o_status       = r_stat;
    assign o_center_x_out = r_cx;
    assign o_center_y_out = r_cy;

endmodule

/* hdl/filled_circle_page_rasterizer.sv */
// Bouncing filled circle on a 128x64 page display: place, tick and render one column.
// Place, tick, undefined and out-of-range render command words each give one status word.
// Other render words pass the front end as radicand, five square root steps of one
// result bit each and job build; the write sequencer then emits one to eight page
// writes (one status word for a column off the display), one per cycle while the output
// is ready, through a registered output; a two-entry job queue lets the next command be
// worked on while earlier writes drain. radius and vert_speed are to be written through
// the plain write port only while the block is idle; the block itself does not enforce it.
module filled_circle_page_rasterizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [fcpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fcpr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [fcpr_pkg::CMD_W-1:0]         i_cmd,
    input  logic [fcpr_pkg::CX_W-1:0]          i_center_x_in,
    input  logic [fcpr_pkg::CY_W-1:0]          i_center_y_in,
    input  logic signed [fcpr_pkg::DIR_W-1:0]  i_dir_x_in,
    input  logic signed [fcpr_pkg::DIR_W-1:0]  i_dir_y_in,
    input  logic [fcpr_pkg::OFS_W-1:0]         i_column_offset,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fcpr_pkg::PAGE_W-1:0]        o_page,
    output logic [fcpr_pkg::CX_W-1:0]          o_column,
    output logic [fcpr_pkg::PIX_W-1:0]         o_pixels,
    output logic                               o_write_valid,
    output logic                               o_last,
    output logic [fcpr_pkg::STAT_W-1:0]        o_status,
    output logic [fcpr_pkg::CX_W-1:0]          o_center_x_out,
    output logic [fcpr_pkg::CY_W-1:0]          o_center_y_out
);
    import fcpr_pkg::*;

    logic    push;
    logic    pop;
    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;

    // command front end
    fcpr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_center_x_in   (i_center_x_in),
        .i_center_y_in   (i_center_y_in),
        .i_dir_x_in      (i_dir_x_in),
        .i_dir_y_in      (i_dir_y_in),
        .i_column_offset (i_column_offset),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_job           (push_job)
    );

    // job queue
    fcpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // write sequencer
    fcpr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_page         (o_page),
        .o_column       (o_column),
        .o_pixels       (o_pixels),
        .o_write_valid  (o_write_valid),
        .o_last         (o_last),
        .o_status       (o_status),
        .o_center_x_out (o_center_x_out),
        .o_center_y_out (o_center_y_out)
    );

endmodule
